FILE: sv/table_atan2_angle_macros.svh
// Assertion macros for the vector angle block.
// Used by the divider cell, the output stage and the top level; no other dependencies.
`ifndef TABLE_ATAN2_ANGLE_MACROS_SVH
`define TABLE_ATAN2_ANGLE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every rising clock edge outside reset.
`define TA2_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define TA2_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`else

`define TA2_ASSERT(label, prop, msg)
`define TA2_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: sv/ta2_pkg.sv
// Shared types, widths, angle constants and the first-octant arctangent table.
// No dependencies; used by every module of the vector angle block.
`timescale 1ns / 1ps

package ta2_pkg;

    // Field and datapath widths.
    localparam int COORD_W   = 16;
    localparam int MAG_W     = 15;
    localparam int QUO_W     = 9;
    localparam int ANGLE_W   = 8;
    localparam int DIV_STEPS = QUO_W;

    // Angle constants in steps of 1/256 turn.
    localparam logic [ANGLE_W-1:0] ANGLE_QUARTER  = 8'h40;
    localparam logic [ANGLE_W-1:0] ANGLE_HALF     = 8'h80;
    localparam logic [ANGLE_W-1:0] ANGLE_OCTANT   = 8'h20;
    localparam logic [ANGLE_W-1:0] ANGLE_ZERO_VEC = 8'h40;

    // Most negative coordinate and the magnitude it saturates to.
    localparam logic [COORD_W-1:0] COORD_MIN = 16'h8000;
    localparam logic [MAG_W-1:0]   MAG_MAX   = 15'h7FFF;

    // Side information that travels alongside the division.
    typedef struct packed {
        logic zero_vec;
        logic neg_x;
        logic neg_y;
        logic x_major;
    } t_ctl;

    // Data carried from one divider cell to the next.
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic             lsb;
        logic [MAG_W-1:0] div;
        logic [QUO_W-1:0] quo;
        t_ctl             ctl;
    } t_div;

    // Arctangent of the first octant, indexed by (small << 8) / large.
    // The quotient 256 (equal magnitudes) is served by ANGLE_OCTANT.
    localparam logic [ANGLE_W-1:0] ARCTAN_ROM [256] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h01, 8'h01, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02,
        8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h04,
        8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h05, 8'h05, 8'h05,
        8'h05, 8'h05, 8'h05, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06,
        8'h06, 8'h06, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07,
        8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h09,
        8'h09, 8'h09, 8'h09, 8'h09, 8'h09, 8'h0A, 8'h0A, 8'h0A,
        8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0B, 8'h0B, 8'h0B, 8'h0B,
        8'h0B, 8'h0B, 8'h0B, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h0C,
        8'h0C, 8'h0C, 8'h0D, 8'h0D, 8'h0D, 8'h0D, 8'h0D, 8'h0D,
        8'h0D, 8'h0E, 8'h0E, 8'h0E, 8'h0E, 8'h0E, 8'h0E, 8'h0E,
        8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h10,
        8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h11, 8'h11,
        8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h12, 8'h12,
        8'h12, 8'h12, 8'h12, 8'h12, 8'h12, 8'h13, 8'h13, 8'h13,
        8'h13, 8'h13, 8'h13, 8'h13, 8'h13, 8'h14, 8'h14, 8'h14,
        8'h14, 8'h14, 8'h14, 8'h14, 8'h14, 8'h15, 8'h15, 8'h15,
        8'h15, 8'h15, 8'h15, 8'h15, 8'h15, 8'h15, 8'h16, 8'h16,
        8'h16, 8'h16, 8'h16, 8'h16, 8'h16, 8'h16, 8'h17, 8'h17,
        8'h17, 8'h17, 8'h17, 8'h17, 8'h17, 8'h17, 8'h17, 8'h18,
        8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18,
        8'h19, 8'h19, 8'h19, 8'h19, 8'h19, 8'h19, 8'h19, 8'h19,
        8'h19, 8'h19, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
        8'h1A, 8'h1A, 8'h1A, 8'h1B, 8'h1B, 8'h1B, 8'h1B, 8'h1B,
        8'h1B, 8'h1B, 8'h1B, 8'h1B, 8'h1B, 8'h1C, 8'h1C, 8'h1C,
        8'h1C, 8'h1C, 8'h1C, 8'h1C, 8'h1C, 8'h1C, 8'h1C, 8'h1C,
        8'h1D, 8'h1D, 8'h1D, 8'h1D, 8'h1D, 8'h1D, 8'h1D, 8'h1D,
        8'h1D, 8'h1D, 8'h1D, 8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1E,
        8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1F, 8'h1F,
        8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F,
        8'h1F, 8'h1F, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20
    };

endpackage

FILE: sv/ta2_front.sv
// Input stage: magnitudes, octant selection and divider operands.
// Depends on ta2_pkg.
`timescale 1ns / 1ps

module ta2_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ta2_pkg::COORD_W-1:0]  i_x_coord,
    input  logic [ta2_pkg::COORD_W-1:0]  i_y_coord,
    output logic                         o_valid,
    input  logic                         i_ready,
    output ta2_pkg::t_div                o_data
);

    logic                        r_valid;
    ta2_pkg::t_div               r_data;
    ta2_pkg::t_div               n_data;
    logic [ta2_pkg::MAG_W-1:0]   w_ax;
    logic [ta2_pkg::MAG_W-1:0]   w_ay;
    logic [ta2_pkg::MAG_W-1:0]   w_small;
    logic [ta2_pkg::MAG_W-1:0]   w_large;
    logic                        w_x_major;

    // Saturating magnitude: the most negative code maps to the largest magnitude.
    function automatic logic [ta2_pkg::MAG_W-1:0] mag(input logic [ta2_pkg::COORD_W-1:0] v);
        logic [ta2_pkg::COORD_W-1:0] neg;
        neg = '0 - v;
        if (v == ta2_pkg::COORD_MIN) begin
            return ta2_pkg::MAG_MAX;
        end else if (v[ta2_pkg::COORD_W-1]) begin
            return neg[ta2_pkg::MAG_W-1:0];
        end else begin
            return v[ta2_pkg::MAG_W-1:0];
        end
    endfunction

    // Pick the octant and hand the smaller magnitude over as the dividend.
    always_comb begin
        w_ax      = mag(i_x_coord);
        w_ay      = mag(i_y_coord);
        w_x_major = (w_ax > w_ay);
        w_small   = w_x_major ? w_ay : w_ax;
        w_large   = w_x_major ? w_ax : w_ay;

        n_data.rem          = {1'b0, w_small[ta2_pkg::MAG_W-1:1]};
        n_data.lsb          = w_small[0];
        n_data.div          = w_large;
        n_data.quo          = '0;
        n_data.ctl.zero_vec = (i_x_coord == '0) && (i_y_coord == '0);
        n_data.ctl.neg_x    = i_x_coord[ta2_pkg::COORD_W-1];
        n_data.ctl.neg_y    = i_y_coord[ta2_pkg::COORD_W-1];
        n_data.ctl.x_major  = w_x_major;
    end

    assign o_ready = !r_valid || i_ready;

    // Stage register; it moves whenever the next stage can take its contents.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/ta2_div_cell.sv
// One restoring-division cell: produces one quotient bit per request and passes it on.
// Depends on ta2_pkg and table_atan2_angle_macros.svh.
`timescale 1ns / 1ps
`include "table_atan2_angle_macros.svh"

module ta2_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ta2_pkg::t_div  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output ta2_pkg::t_div  o_data
);

    logic                        r_valid;
    ta2_pkg::t_div               r_data;
    ta2_pkg::t_div               n_data;
    logic [ta2_pkg::MAG_W:0]     w_trial;
    logic [ta2_pkg::MAG_W:0]     w_diff;
    logic                        w_ge;

    // Shift in the next dividend bit and subtract the divisor if it fits.
    always_comb begin
        w_trial    = {i_data.rem, i_data.lsb};
        w_diff     = w_trial - {1'b0, i_data.div};
        w_ge       = (w_trial >= {1'b0, i_data.div});
        n_data     = i_data;
        n_data.rem = w_ge ? w_diff[ta2_pkg::MAG_W-1:0] : w_trial[ta2_pkg::MAG_W-1:0];
        n_data.lsb = 1'b0;
        n_data.quo = {i_data.quo[ta2_pkg::QUO_W-2:0], w_ge};
    end

    assign o_ready = !r_valid || i_ready;

    // Cell register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // The partial remainder always stays below a nonzero divisor.
    `TA2_ASSERT(a_rem_below_div, r_valid && (r_data.div != '0) |-> (r_data.rem < r_data.div), "division cell remainder not below divisor")
    // A held request is not dropped while the next cell stalls.
    `TA2_ASSERT(a_hold_on_stall, r_valid && !i_ready |=> r_valid, "division cell lost a stalled request")

endmodule

FILE: sv/ta2_back.sv
// Output stage: arctangent lookup, folding into the full turn and the result register.
// Depends on ta2_pkg and table_atan2_angle_macros.svh.
`timescale 1ns / 1ps
`include "table_atan2_angle_macros.svh"

module ta2_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  ta2_pkg::t_div                i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ta2_pkg::ANGLE_W-1:0]  o_angle
);

    logic                         r_valid;
    logic [ta2_pkg::ANGLE_W-1:0]  r_angle;
    logic [ta2_pkg::ANGLE_W-1:0]  n_angle;
    logic [ta2_pkg::ANGLE_W-1:0]  w_oct;
    logic [ta2_pkg::ANGLE_W-1:0]  w_quad;
    logic [ta2_pkg::ANGLE_W-1:0]  w_half;

    // Table lookup, then reflect by octant, by the sign of x and by the sign of y; a zero vector gives ANGLE_ZERO_VEC.
    always_comb begin
        if (i_data.quo[ta2_pkg::QUO_W-1]) begin
            w_oct = ta2_pkg::ANGLE_OCTANT;
        end else begin
            w_oct = ta2_pkg::ARCTAN_ROM[i_data.quo[ta2_pkg::QUO_W-2:0]];
        end
        w_quad = i_data.ctl.x_major ? w_oct : (ta2_pkg::ANGLE_QUARTER - w_oct);
        w_half = i_data.ctl.neg_x ? (ta2_pkg::ANGLE_HALF - w_quad) : w_quad;
        // A full turn is 256 steps, so the lower-half reflection is a negation.
        n_angle = i_data.ctl.neg_y ? (8'h00 - w_half) : w_half;
        if (i_data.ctl.zero_vec) begin
            n_angle = ta2_pkg::ANGLE_ZERO_VEC;
        end
    end

    assign o_ready = !r_valid || i_ready;

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_valid;
    assign o_angle = r_angle;

    // A full-scale quotient only arises when the magnitudes are equal.
    `TA2_ASSERT(a_full_quo_octant, i_valid && !i_data.ctl.zero_vec && i_data.quo[ta2_pkg::QUO_W-1] |-> !i_data.ctl.x_major && (i_data.quo[ta2_pkg::QUO_W-2:0] == '0), "full-scale quotient outside the diagonal")

endmodule

FILE: sv/table_atan2_angle.sv
// Top level of the vector angle block: input stage, nine divider cells, output stage.
// Depends on ta2_pkg, ta2_front, ta2_div_cell, ta2_back and table_atan2_angle_macros.svh.
//
//  Channel   Valid        Ready        Payload
//  -------   ----------   ----------   ----------------------
//  input     i_in_valid   o_in_ready   i_x_coord, i_y_coord
//  output    o_out_valid  i_out_ready  o_angle
//
// One request enters per cycle while o_in_ready is high; each request passes through
// one input stage, one divider cell per quotient bit (nine) and one lookup stage.
// Every stage holds at most one request, so a stall at the output fills empty
// stages first and only then lowers o_in_ready.
// Reset clears the stage valid flags only; there is no clearing pass.
`timescale 1ns / 1ps
`include "table_atan2_angle_macros.svh"

module table_atan2_angle (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ta2_pkg::COORD_W-1:0]  i_x_coord,
    input  logic [ta2_pkg::COORD_W-1:0]  i_y_coord,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ta2_pkg::ANGLE_W-1:0]  o_angle
);

    logic           w_valid [ta2_pkg::DIV_STEPS+1];
    logic           w_ready [ta2_pkg::DIV_STEPS+1];
    ta2_pkg::t_div  w_data  [ta2_pkg::DIV_STEPS+1];

    // Magnitudes and operand set-up.
    ta2_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .o_valid   (w_valid[0]),
        .i_ready   (w_ready[0]),
        .o_data    (w_data[0])
    );

    // Row of division cells, most significant quotient bit first.
    for (genvar k = 0; k < ta2_pkg::DIV_STEPS; k++) begin : g_cell
        ta2_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    // Lookup, folding and result register.
    ta2_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[ta2_pkg::DIV_STEPS]),
        .o_ready (w_ready[ta2_pkg::DIV_STEPS]),
        .i_data  (w_data[ta2_pkg::DIV_STEPS]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_angle (o_angle)
    );

    // Back-pressure at the input only when a result is waiting at the output.
    `TA2_ASSERT(a_stall_needs_result, !o_in_ready |-> o_out_valid, "input stalled with no result waiting")
    // Nothing is shown at the output once reset has been sampled low.
    `TA2_ASSERT_ALWAYS(a_reset_empty, !$past(i_rst_n) |-> !o_out_valid, "result shown straight after reset")

endmodule
